[design/oft_pkg.sv]
// shared types, codes and defaults for the ordered forwarding table
`timescale 1ns / 1ps

package oft_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int DEFAULT_PORT_BITS   = 8;

   localparam logic [2:0] MODE_LOOKUP_EXACT     = 3'd0;
   localparam logic [2:0] MODE_LOOKUP_ADDR      = 3'd1;
   localparam logic [2:0] MODE_INSERT_CHECKED   = 3'd2;
   localparam logic [2:0] MODE_INSERT_UNCHECKED = 3'd3;
   localparam logic [2:0] MODE_REMOVE           = 3'd4;
   localparam logic [2:0] MODE_CLEAR            = 3'd5;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] dest_addr;
      logic [15:0] qos_id;
      logic [7:0]  port_in;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] port_out;
      logic [1:0] status;
      logic [4:0] removed_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       hit;
      logic       scan_done;
   } dp_stat_type;

endpackage

[design/oft_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module oft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/oft_ctrl.sv]
// controller state machine sequencing load, scan and finish of a transaction
`timescale 1ns / 1ps

module oft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  oft_pkg::dp_stat_type stat,
   output oft_pkg::ctrl_cmd_type cmd
);
   import oft_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      needs_scan;
   logic      early_exit;

   always_comb begin
      needs_scan = (stat.mode == MODE_LOOKUP_EXACT) || (stat.mode == MODE_LOOKUP_ADDR) ||
                   (stat.mode == MODE_INSERT_CHECKED) || (stat.mode == MODE_REMOVE);
      early_exit = stat.hit && (stat.mode != MODE_REMOVE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!needs_scan || early_exit || stat.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: begin
            cmd.scan = needs_scan;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> state_ff == ST_IDLE)
      else $error("finish not followed by idle");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.finish}))
      else $error("overlapping datapath commands");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule

[design/oft_datapath.sv]
// datapath: entry ram, request and scan registers, compare and result logic
`timescale 1ns / 1ps

module oft_datapath #(
   parameter int TABLE_DEPTH = oft_pkg::DEFAULT_TABLE_DEPTH,
   parameter int PORT_BITS   = oft_pkg::DEFAULT_PORT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  oft_pkg::req_type      req_item,
   input  oft_pkg::ctrl_cmd_type cmd,
   output oft_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   output oft_pkg::rsp_type      rsp_item
);
   import oft_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 32 + PORT_BITS;
   localparam int PW = (PORT_BITS > 8) ? PORT_BITS : 8;
   localparam int SW = (CW > 5) ? CW : 5;

   req_type              req_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]        removed_ff, removed_in;
   logic                 found_ff, found_in;
   logic [PORT_BITS-1:0] port_ff, port_in_q;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic                 rd_en;
   logic [EW-1:0]        rd_data;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic [15:0]          ent_addr;
   logic [15:0]          ent_qos;
   logic [PORT_BITS-1:0] ent_port;
   logic                 addr_eq;
   logic                 exact;
   logic                 match;
   logic                 hit;
   logic                 is_remove;
   logic                 keep;
   logic                 full;
   logic                 append;
   logic [PW-1:0]        port_wide_in;
   logic [PORT_BITS-1:0] port_store;
   logic [PW-1:0]        port_wide_out;
   logic [SW-1:0]        removed_wide;
   logic [SW-1:0]        count_wide;
   logic [4:0]           removed_sat;
   logic [4:0]           count_sat;

   oft_ram #(
      .WIDTH(EW),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_idx_ff[IW-1:0]),
      .rd_data(rd_data)
   );

   // compare and write port
   always_comb begin
      ent_addr  = rd_data[EW-1 -: 16];
      ent_qos   = rd_data[PORT_BITS +: 16];
      ent_port  = rd_data[PORT_BITS-1:0];
      addr_eq   = ent_addr == req_ff.dest_addr;
      exact     = addr_eq && (ent_qos == req_ff.qos_id);
      match     = (req_ff.mode == MODE_LOOKUP_ADDR) ? addr_eq : exact;
      hit       = pend_ff && match;
      is_remove = req_ff.mode == MODE_REMOVE;
      rd_en     = cmd.scan && (rd_idx_ff < count_ff);
      keep      = cmd.scan && pend_ff && is_remove && !exact;
      full      = count_ff == CW'(TABLE_DEPTH);
      append    = cmd.finish && !full &&
                  ((req_ff.mode == MODE_INSERT_UNCHECKED) ||
                   ((req_ff.mode == MODE_INSERT_CHECKED) && !found_ff));

      port_wide_in = PW'(req_ff.port_in);
      port_store   = port_wide_in[PORT_BITS-1:0];

      wr_en   = keep || append;
      wr_addr = keep ? wr_ptr_ff[IW-1:0] : count_ff[IW-1:0];
      wr_data = keep ? rd_data : {req_ff.dest_addr, req_ff.qos_id, port_store};

      stat.mode      = req_ff.mode;
      stat.hit       = hit;
      stat.scan_done = !pend_ff && !(rd_idx_ff < count_ff);
   end

   // scan registers
   always_comb begin
      rd_idx_in  = rd_idx_ff;
      pend_in    = 1'b0;
      wr_ptr_in  = wr_ptr_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      port_in_q  = port_ff;
      if (cmd.load) begin
         rd_idx_in  = '0;
         wr_ptr_in  = '0;
         removed_in = '0;
         found_in   = 1'b0;
         port_in_q  = '0;
      end else if (cmd.scan) begin
         rd_idx_in = rd_idx_ff + CW'(rd_en);
         pend_in   = rd_en;
         if (keep) begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
         if (pend_ff && is_remove && exact) begin
            removed_in = removed_ff + 1'b1;
         end
         if (hit && !is_remove) begin
            found_in  = 1'b1;
            port_in_q = ent_port;
         end
      end
   end

   // result and entry count
   always_comb begin
      removed_wide  = SW'(removed_ff);
      count_wide    = SW'(count_ff);
      removed_sat   = (removed_wide > SW'(31)) ? 5'd31 : removed_wide[4:0];
      count_sat     = (count_wide > SW'(31)) ? 5'd31 : count_wide[4:0];
      port_wide_out = PW'(port_ff);
      rsp_in        = '0;
      count_in      = count_ff;
      if (cmd.finish) begin
         case (req_ff.mode) inside
            MODE_LOOKUP_EXACT, MODE_LOOKUP_ADDR: begin
               rsp_in.found    = found_ff;
               rsp_in.port_out = port_wide_out[7:0];
            end
            MODE_INSERT_CHECKED: begin
               if (found_ff) begin
                  rsp_in.status = STATUS_DUPLICATE;
               end else if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status = STATUS_DONE;
               end
            end
            MODE_INSERT_UNCHECKED: begin
               rsp_in.status = full ? STATUS_FULL : STATUS_DONE;
            end
            MODE_REMOVE: begin
               rsp_in.removed_count = removed_sat;
               count_in             = wr_ptr_ff;
            end
            MODE_CLEAR: begin
               rsp_in.removed_count = count_sat;
               count_in             = '0;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
         if (append) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
      rd_idx_ff  <= rd_idx_in;
      wr_ptr_ff  <= wr_ptr_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
      port_ff    <= port_in_q;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> wr_ptr_ff <= rd_idx_ff)
      else $error("compaction write overtook read");

   a_lookup_fields_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.status == STATUS_DONE &&
                                       rsp_ff.removed_count == 5'd0)
      else $error("lookup hit carries insert or remove fields");

endmodule

[design/ordered_forwarding_table.sv]
// top level of the ordered exact-match forwarding table
`timescale 1ns / 1ps

// Ordered forwarding table: up to TABLE_DEPTH entries of destination address, QoS id
// and port, kept in insertion order in one ram. A transaction is taken when start is
// high and busy is low; its single result shows on rsp_item for one cycle with
// rsp_valid high and must be taken then, since the receiver cannot stall. Clear,
// unchecked insert and unused modes pass through scan and finish without reading
// the ram. Lookups, checked insert and remove walk the entries through the ram read
// port, one entry per cycle, lookups and checked insert stopping at the first match.
// The result shows in the cycle in which busy falls, which is also the first cycle
// a new transaction can be taken. Remove compacts in the same pass by writing kept
// entries back behind the read pointer. Entry contents are not cleared at reset;
// only entries below the count are read.

module ordered_forwarding_table #(
   parameter int TABLE_DEPTH = oft_pkg::DEFAULT_TABLE_DEPTH,
   parameter int PORT_BITS   = oft_pkg::DEFAULT_PORT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  oft_pkg::req_type req_item,
   output logic             rsp_valid,
   output oft_pkg::rsp_type rsp_item
);
   import oft_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   oft_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   oft_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .PORT_BITS  (PORT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

endmodule
